>>> hw/rtl/sorted_priority_list_assert.svh
// Assertion macros for the sorted priority list, clocked on clk and disabled in reset.
`ifndef SORTED_PRIORITY_LIST_ASSERT_SVH
`define SORTED_PRIORITY_LIST_ASSERT_SVH

`ifndef SYNTH
`define SPL_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sorted_priority_list: check failed");
`define SPL_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted_priority_list: check failed");
`define SPL_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted_priority_list: check failed");
`else
`define SPL_ASSERT(name, prop)
`define SPL_IMPLY(name, ante, cons)
`define SPL_NEXT(name, ante, cons)
`endif

`endif

>>> hw/rtl/spl_pkg.sv
// Shared types and constants for the sorted priority list.
package spl_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int KEY_W         = 64;
    localparam int GRADE_W       = 16;
    localparam int POS_W         = 4;
    localparam int STATUS_W      = 2;
    localparam int COUNT_W       = 5;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_FIND   = 3'd1,
        OP_DELETE = 3'd2,
        OP_CHANGE = 3'd3,
        OP_READ   = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_INSERT,
        CMD_FIND,
        CMD_REMOVE,
        CMD_READ
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic valid;    // cell index below the fill count
        logic tail;     // cell index equals the fill count
        logic pos_hit;  // cell index equals the requested position
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REINS
    } state_t;

endpackage

>>> hw/rtl/spl_cell.sv
// One slot of the list: holds an entry and moves it to or from its neighbors.
module spl_cell (
    input  logic                                 clk,
    input  spl_pkg::cell_ctrl_t                  ctrl,
    input  logic        [spl_pkg::KEY_W-1:0]     new_key,
    input  logic signed [spl_pkg::GRADE_W-1:0]   new_grade,
    input  logic                                 left_lower,
    input  logic        [spl_pkg::KEY_W-1:0]     left_key,
    input  logic signed [spl_pkg::GRADE_W-1:0]   left_grade,
    input  logic        [spl_pkg::KEY_W-1:0]     right_key,
    input  logic signed [spl_pkg::GRADE_W-1:0]   right_grade,
    input  logic                                 seen_in,
    output logic                                 seen_out,
    output logic                                 lower,
    output logic        [spl_pkg::KEY_W-1:0]     key,
    output logic signed [spl_pkg::GRADE_W-1:0]   grade,
    output logic        [spl_pkg::KEY_W-1:0]     sel_key,
    output logic signed [spl_pkg::GRADE_W-1:0]   sel_grade
);
    import spl_pkg::*;

    logic        [KEY_W-1:0]   key_reg;
    logic        [KEY_W-1:0]   key_next;
    logic signed [GRADE_W-1:0] grade_reg;
    logic signed [GRADE_W-1:0] grade_next;
    logic                      match;
    logic                      first;
    logic                      sel;

    assign lower    = ctrl.valid && (grade_reg < new_grade);
    assign match    = ctrl.valid && (key_reg == new_key);
    assign first    = match && !seen_in;
    assign seen_out = seen_in || match;

    always_comb
    begin
        key_next   = key_reg;
        grade_next = grade_reg;
        sel        = 1'b0;
        case (ctrl.cmd)
            CMD_INSERT:
            begin
                // grades are descending, so every cell past the slot sees a lower left
                if (left_lower)
                begin
                    key_next   = left_key;
                    grade_next = left_grade;
                end
                else if (lower || ctrl.tail)
                begin
                    key_next   = new_key;
                    grade_next = new_grade;
                end
            end
            CMD_FIND:
            begin
                sel = first;
            end
            CMD_REMOVE:
            begin
                sel = first;
                if (seen_out)
                begin
                    key_next   = right_key;
                    grade_next = right_grade;
                end
            end
            CMD_READ:
            begin
                sel = ctrl.pos_hit && ctrl.valid;
            end
            default:
            begin
                sel = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        grade_reg <= grade_next;
    end

    assign key       = key_reg;
    assign grade     = grade_reg;
    assign sel_key   = sel ? key_reg : '0;
    assign sel_grade = sel ? grade_reg : '0;

endmodule

>>> hw/rtl/sorted_priority_list.sv
// Top level of the sorted priority list: control sequencer and the chain of cells.
//
// Command interface. A transaction is accepted at a clock edge where start is high
// and busy is low; operation, key, grade and position are sampled there.
// Exactly one result comes back per transaction: done is high for one cycle with
// status, found_key, found_grade and entry_count valid in that cycle.
// Insert, find, delete, read, clear and unknown codes run in the execute state, then
// show done; change grade with a found key runs the execute state, then the re-insert
// state (one pass of the chain to remove the entry, one to re-insert it).
// busy drops in the done cycle, so a new command can be accepted while the result is
// shown. Each pass is one shift of the whole cell chain.
// The list is kept in a row of DEPTH cells sorted by descending grade; insert and
// delete move all affected entries one cell in one pass.
// Reset (rst_n low) empties the list; slot contents are left as they are.
// The receiver cannot stall: a result must be taken in its done cycle.
module sorted_priority_list #(
    parameter int DEPTH = spl_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic        [2:0]                    operation,
    input  logic        [spl_pkg::KEY_W-1:0]     key,
    input  logic signed [spl_pkg::GRADE_W-1:0]   grade,
    input  logic        [spl_pkg::POS_W-1:0]     position,
    output logic                                 done,
    output logic        [spl_pkg::STATUS_W-1:0]  status,
    output logic        [spl_pkg::KEY_W-1:0]     found_key,
    output logic signed [spl_pkg::GRADE_W-1:0]   found_grade,
    output logic        [spl_pkg::COUNT_W-1:0]   entry_count
);
    import spl_pkg::*;

    `include "sorted_priority_list_assert.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          count_next;
    logic                      done_reg;
    logic                      done_next;

    logic [2:0]                op_reg;
    logic [KEY_W-1:0]          key_reg;
    logic signed [GRADE_W-1:0] grade_reg;
    logic [POS_W-1:0]          pos_reg;

    status_t                   status_reg;
    status_t                   status_next;
    logic [KEY_W-1:0]          found_key_reg;
    logic [KEY_W-1:0]          found_key_next;
    logic signed [GRADE_W-1:0] found_grade_reg;
    logic signed [GRADE_W-1:0] found_grade_next;

    cmd_t                      cmd;
    logic                      accept;
    logic                      any_hit;
    logic                      pos_ok;

    cell_ctrl_t                ctrl      [DEPTH];
    logic [KEY_W-1:0]          cell_key  [DEPTH];
    logic signed [GRADE_W-1:0] cell_grade[DEPTH];
    logic [KEY_W-1:0]          sel_key   [DEPTH];
    logic signed [GRADE_W-1:0] sel_grade [DEPTH];
    logic                      lower     [DEPTH];
    logic                      seen      [DEPTH+1];
    logic [KEY_W-1:0]          or_key;
    logic signed [GRADE_W-1:0] or_grade;

    assign accept  = start && (state_reg == S_IDLE);
    assign seen[0] = 1'b0;
    assign any_hit = seen[DEPTH];
    assign pos_ok  = 32'(pos_reg) < 32'(count_reg);

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic        [KEY_W-1:0]   l_key;
        logic signed [GRADE_W-1:0] l_grade;
        logic                      l_lower;
        logic        [KEY_W-1:0]   r_key;
        logic signed [GRADE_W-1:0] r_grade;

        assign ctrl[i].cmd     = cmd;
        assign ctrl[i].valid   = count_reg > CNT_W'(i);
        assign ctrl[i].tail    = count_reg == CNT_W'(i);
        assign ctrl[i].pos_hit = 32'(pos_reg) == i;

        if (i == 0)
        begin : g_head
            assign l_key   = '0;
            assign l_grade = '0;
            assign l_lower = 1'b0;
        end
        else
        begin : g_body
            assign l_key   = cell_key[i-1];
            assign l_grade = cell_grade[i-1];
            assign l_lower = lower[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_key   = cell_key[i];
            assign r_grade = cell_grade[i];
        end
        else
        begin : g_mid
            assign r_key   = cell_key[i+1];
            assign r_grade = cell_grade[i+1];
        end

        spl_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl[i]),
            .new_key     (key_reg),
            .new_grade   (grade_reg),
            .left_lower  (l_lower),
            .left_key    (l_key),
            .left_grade  (l_grade),
            .right_key   (r_key),
            .right_grade (r_grade),
            .seen_in     (seen[i]),
            .seen_out    (seen[i+1]),
            .lower       (lower[i]),
            .key         (cell_key[i]),
            .grade       (cell_grade[i]),
            .sel_key     (sel_key[i]),
            .sel_grade   (sel_grade[i])
        );
    end

    // at most one cell drives a nonzero selection
    always_comb
    begin
        or_key   = '0;
        or_grade = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            or_key   = or_key | sel_key[i];
            or_grade = or_grade | sel_grade[i];
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        done_next        = 1'b0;
        cmd              = CMD_HOLD;
        status_next      = status_reg;
        found_key_next   = found_key_reg;
        found_grade_next = found_grade_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next       = S_IDLE;
                done_next        = 1'b1;
                status_next      = ST_OK;
                found_key_next   = '0;
                found_grade_next = '0;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd        = CMD_INSERT;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    OP_FIND:
                    begin
                        cmd = CMD_FIND;
                        if (any_hit)
                        begin
                            found_key_next   = or_key;
                            found_grade_next = or_grade;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_DELETE:
                    begin
                        cmd = CMD_REMOVE;
                        if (any_hit)
                        begin
                            found_key_next   = or_key;
                            found_grade_next = or_grade;
                            count_next       = count_reg - CNT_W'(1);
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_CHANGE:
                    begin
                        cmd = CMD_REMOVE;
                        if (any_hit)
                        begin
                            found_key_next   = or_key;
                            found_grade_next = grade_reg;
                            count_next       = count_reg - CNT_W'(1);
                            state_next       = S_REINS;
                            done_next        = 1'b0;
                        end
                        else
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    end
                    OP_READ:
                    begin
                        cmd = CMD_READ;
                        if (pos_ok)
                        begin
                            found_key_next   = or_key;
                            found_grade_next = or_grade;
                        end
                        else
                        begin
                            status_next = ST_EMPTY;
                        end
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        cmd = CMD_HOLD;
                    end
                endcase
            end
            S_REINS:
            begin
                // removal just freed a slot, so the list cannot be full here
                cmd        = CMD_INSERT;
                count_next = count_reg + CNT_W'(1);
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            key_reg   <= key;
            grade_reg <= grade;
            pos_reg   <= position;
        end
        status_reg      <= status_next;
        found_key_reg   <= found_key_next;
        found_grade_reg <= found_grade_next;
    end

    assign busy        = state_reg != S_IDLE;
    assign done        = done_reg;
    assign status      = status_reg;
    assign found_key   = found_key_reg;
    assign found_grade = found_grade_reg;
    assign entry_count = COUNT_W'(count_reg);

    `SPL_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH))
    `SPL_NEXT(a_done_single, done_reg, !done_reg)
    `SPL_NEXT(a_accept_busy, start && !busy, busy && !done_reg)
    `SPL_IMPLY(a_full_status, done_reg && status_reg == ST_FULL, count_reg == CNT_W'(DEPTH))
    `SPL_IMPLY(a_reins_room, state_reg == S_REINS, count_reg < CNT_W'(DEPTH))

endmodule
